### rtl/tbf_pkg.sv
// Shared types, register indexes, reset values and axis remap for the three-axis biquad filter.
package tbf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int MAP_W      = 3;
   localparam int RESULT_W   = 24;
   localparam int AXES       = 3;
   localparam int REQ_DATA_W = AXES * SAMPLE_W;
   localparam int RSP_DATA_W = AXES * RESULT_W;
   localparam int CSR_DATA_W = 16;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic [MAP_W-1:0]           map_type;
   typedef logic signed [RESULT_W-1:0] result_type;
   typedef logic [2:0]                 csr_index_type;
   typedef logic [1:0]                 axis_type;

   localparam csr_index_type CSR_COEF_B0 = 3'd0;
   localparam csr_index_type CSR_COEF_B1 = 3'd1;
   localparam csr_index_type CSR_COEF_B2 = 3'd2;
   localparam csr_index_type CSR_COEF_A1 = 3'd3;
   localparam csr_index_type CSR_COEF_A2 = 3'd4;
   localparam csr_index_type CSR_MAP_X   = 3'd5;
   localparam csr_index_type CSR_MAP_Y   = 3'd6;
   localparam csr_index_type CSR_MAP_Z   = 3'd7;

   localparam coef_type RESET_B0 = 16'sd16384;
   localparam coef_type RESET_B1 = -16'sd22938;
   localparam coef_type RESET_B2 = 16'sd16384;
   localparam coef_type RESET_A1 = -16'sd21299;
   localparam coef_type RESET_A2 = 16'sd8192;
   localparam map_type  RESET_MAP_X = 3'd0;
   localparam map_type  RESET_MAP_Y = 3'd2;
   localparam map_type  RESET_MAP_Z = 3'd4;

   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   localparam sample_type SAMPLE_MAX = 16'sh7FFF;
   localparam sample_type SAMPLE_MIN = 16'sh8000;

   function automatic sample_type pick_axis(input map_type sel, input sample_type rx,
                                            input sample_type ry, input sample_type rz);
      sample_type v;
      v = '0;
      case (sel[2:1])
         AXIS_X:  v = rx;
         AXIS_Y:  v = ry;
         AXIS_Z:  v = rz;
         default: v = '0;
      endcase
      if (sel[0] && (sel[2:1] != 2'd3)) begin
         if (v == SAMPLE_MIN) begin
            v = SAMPLE_MAX;
         end else begin
            v = -v;
         end
      end
      return v;
   endfunction

endpackage

### rtl/three_axis_biquad_filter_core.sv
// Three-axis remap and per-axis biquad section on one shared multiplier.
//
// Each accepted beat carries one raw sample per axis; every output axis is taken from a
// chosen source axis (optionally negated, with -32768 negating to 32767) and filtered by
// its own transposed direct form II section with Q(COEF_FRAC_BITS) coefficients and two
// STATE_WIDTH-bit delay words. A single signed 16 x (STATE_WIDTH/2+1) multiplier forms
// seven products per axis (b0, b1 and b2 times the sample, then a1 and a2 times the
// accumulator in two halves), and a nine-step sequencer runs the axes one after another,
// so a result is offered in the same cycle as the input is ready again, provided the
// previous result has been taken; no new beat is accepted while one is in flight.
// Configuration writes are taken in every cycle and must only be made while no sample is
// in flight.
module three_axis_biquad_filter_core #(
   parameter int COEF_FRAC_BITS = 14,
   parameter int STATE_WIDTH    = 40
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // raw_x [15:0], raw_y [31:16], raw_z [47:32]
   input  logic [tbf_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // filtered_x [23:0], filtered_y [47:24], filtered_z [71:48]
   output logic [tbf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  tbf_pkg::csr_index_type            csr_index,
   input  logic [tbf_pkg::CSR_DATA_W-1:0]    csr_data
);
   import tbf_pkg::*;

   localparam int LO = STATE_WIDTH / 2;
   localparam int BW = LO + 1;
   localparam int PW = COEF_W + BW;
   localparam int W  = STATE_WIDTH + 18;

   localparam logic signed [W-1:0] HALF =
      {{(W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
   localparam logic signed [W-1:0] STATE_MAX =
      {{(W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [W-1:0] STATE_MIN = ~STATE_MAX;
   localparam logic signed [W-1:0] OUT_MAX =
      {{(W-RESULT_W+1){1'b0}}, {(RESULT_W-1){1'b1}}};
   localparam logic signed [W-1:0] OUT_MIN = ~OUT_MAX;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   localparam logic [3:0] STEP_B0      = 4'd0;
   localparam logic [3:0] STEP_B1_ACC  = 4'd1;
   localparam logic [3:0] STEP_B2_T1   = 4'd2;
   localparam logic [3:0] STEP_A1LO_T2 = 4'd3;
   localparam logic [3:0] STEP_A1HI_M  = 4'd4;
   localparam logic [3:0] STEP_A2LO_M  = 4'd5;
   localparam logic [3:0] STEP_A2HI_D1 = 4'd6;
   localparam logic [3:0] STEP_M2      = 4'd7;
   localparam logic [3:0] STEP_D2      = 4'd8;

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   axis_type   axis_ff, axis_in;

   coef_type b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in, a1_ff, a1_in, a2_ff, a2_in;
   map_type  map_x_ff, map_x_in, map_y_ff, map_y_in, map_z_ff, map_z_in;

   logic signed [STATE_WIDTH-1:0] d1_ff [0:AXES-1];
   logic signed [STATE_WIDTH-1:0] d1_in [0:AXES-1];
   logic signed [STATE_WIDTH-1:0] d2_ff [0:AXES-1];
   logic signed [STATE_WIDTH-1:0] d2_in [0:AXES-1];

   sample_type x_ff [0:AXES-1];
   sample_type x_in [0:AXES-1];
   result_type res_ff [0:AXES-1];
   result_type res_in [0:AXES-1];

   logic signed [STATE_WIDTH-1:0] acc_ff, acc_in;
   logic signed [W-1:0]           t1_ff, t1_in, t2_ff, t2_in, m_ff, m_in;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [COEF_W-1:0]      op_a;
   logic signed [BW-1:0]          op_b;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic signed [W-1:0] prod_w, sum_w, round_w;
   logic                in_beat, out_free;

   function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [W-1:0] v);
      if (v > STATE_MAX) begin
         return STATE_MAX[STATE_WIDTH-1:0];
      end else if (v < STATE_MIN) begin
         return STATE_MIN[STATE_WIDTH-1:0];
      end
      return v[STATE_WIDTH-1:0];
   endfunction

   function automatic result_type sat_out(input logic signed [W-1:0] v);
      if (v > OUT_MAX) begin
         return OUT_MAX[RESULT_W-1:0];
      end else if (v < OUT_MIN) begin
         return OUT_MIN[RESULT_W-1:0];
      end
      return v[RESULT_W-1:0];
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign in_beat    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // shared multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (step_ff)
         STEP_B0: begin
            op_a = b0_ff;
            op_b = BW'(x_ff[axis_ff]);
         end
         STEP_B1_ACC: begin
            op_a = b1_ff;
            op_b = BW'(x_ff[axis_ff]);
         end
         STEP_B2_T1: begin
            op_a = b2_ff;
            op_b = BW'(x_ff[axis_ff]);
         end
         STEP_A1LO_T2: begin
            op_a = a1_ff;
            op_b = $signed({1'b0, acc_ff[LO-1:0]});
         end
         STEP_A1HI_M: begin
            op_a = a1_ff;
            op_b = BW'($signed(acc_ff[STATE_WIDTH-1:LO]));
         end
         STEP_A2LO_M: begin
            op_a = a2_ff;
            op_b = $signed({1'b0, acc_ff[LO-1:0]});
         end
         STEP_A2HI_D1: begin
            op_a = a2_ff;
            op_b = BW'($signed(acc_ff[STATE_WIDTH-1:LO]));
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;
   assign prod_w  = W'(prod_ff);
   assign round_w = (W'(acc_ff) + HALF) >>> COEF_FRAC_BITS;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      axis_in      = axis_ff;
      acc_in       = acc_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      m_in         = m_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      x_in         = x_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      sum_w        = '0;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      map_x_in     = map_x_ff;
      map_y_in     = map_y_ff;
      map_z_in     = map_z_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_COEF_B0: b0_in    = coef_type'(csr_data);
            CSR_COEF_B1: b1_in    = coef_type'(csr_data);
            CSR_COEF_B2: b2_in    = coef_type'(csr_data);
            CSR_COEF_A1: a1_in    = coef_type'(csr_data);
            CSR_COEF_A2: a2_in    = coef_type'(csr_data);
            CSR_MAP_X:   map_x_in = csr_data[MAP_W-1:0];
            CSR_MAP_Y:   map_y_in = csr_data[MAP_W-1:0];
            CSR_MAP_Z:   map_z_in = csr_data[MAP_W-1:0];
            default:     b0_in    = b0_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_beat) begin
               x_in[0]  = pick_axis(map_x_ff, req_tdata[15:0], req_tdata[31:16],
                                    req_tdata[47:32]);
               x_in[1]  = pick_axis(map_y_ff, req_tdata[15:0], req_tdata[31:16],
                                    req_tdata[47:32]);
               x_in[2]  = pick_axis(map_z_ff, req_tdata[15:0], req_tdata[31:16],
                                    req_tdata[47:32]);
               axis_in  = AXIS_X;
               step_in  = STEP_B0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               STEP_B0: begin
                  acc_in = acc_ff;
               end
               STEP_B1_ACC: begin
                  sum_w  = prod_w + W'(d1_ff[axis_ff]);
                  acc_in = sat_state(sum_w);
               end
               STEP_B2_T1: begin
                  t1_in           = prod_w + W'(d2_ff[axis_ff]);
                  res_in[axis_ff] = sat_out(round_w);
               end
               STEP_A1LO_T2: begin
                  t2_in = prod_w;
               end
               STEP_A1HI_M: begin
                  m_in = prod_w + HALF;
               end
               STEP_A2LO_M: begin
                  m_in = m_ff + (prod_w <<< LO);
               end
               STEP_A2HI_D1: begin
                  sum_w          = t1_ff - (m_ff >>> COEF_FRAC_BITS);
                  d1_in[axis_ff] = sat_state(sum_w);
                  m_in           = prod_w + HALF;
               end
               STEP_M2: begin
                  m_in = m_ff + (prod_w <<< LO);
               end
               STEP_D2: begin
                  sum_w          = t2_ff - (m_ff >>> COEF_FRAC_BITS);
                  d2_in[axis_ff] = sat_state(sum_w);
                  step_in        = STEP_B0;
                  if (axis_ff == AXIS_Z) begin
                     state_in = ST_HOLD;
                  end else begin
                     axis_in = axis_ff + 2'd1;
                  end
               end
               default: begin
                  step_in = STEP_B0;
               end
            endcase
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_ff[2], res_ff[1], res_ff[0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_B0;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
         b0_ff        <= RESET_B0;
         b1_ff        <= RESET_B1;
         b2_ff        <= RESET_B2;
         a1_ff        <= RESET_A1;
         a2_ff        <= RESET_A2;
         map_x_ff     <= RESET_MAP_X;
         map_y_ff     <= RESET_MAP_Y;
         map_z_ff     <= RESET_MAP_Z;
         for (int i = 0; i < AXES; i++) begin
            d1_ff[i] <= '0;
            d2_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         b0_ff        <= b0_in;
         b1_ff        <= b1_in;
         b2_ff        <= b2_in;
         a1_ff        <= a1_in;
         a2_ff        <= a2_in;
         map_x_ff     <= map_x_in;
         map_y_ff     <= map_y_in;
         map_z_ff     <= map_z_in;
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      m_ff        <= m_in;
      x_ff        <= x_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
